FILE: rtl/clsc_pkg.sv
// Shared types and constants of the current-loop sensor conditioner.
`default_nettype none

package clsc_pkg;

	typedef struct packed {
		logic [15:0] sample_voltage;
		logic        adc_ok;
	} sample_t;

	typedef struct packed {
		logic [16:0]        loop_current;
		logic [2:0]         fault_code;
		logic signed [31:0] scaled_value;
		logic signed [31:0] filtered_value;
	} result_t;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t REG_SHUNT    = 3'd0;
	localparam cfg_idx_t REG_CUR_LOW  = 3'd1;
	localparam cfg_idx_t REG_CUR_HIGH = 3'd2;
	localparam cfg_idx_t REG_ENG_LOW  = 3'd3;
	localparam cfg_idx_t REG_ENG_HIGH = 3'd4;
	localparam cfg_idx_t REG_ALPHA    = 3'd5;

	localparam logic [2:0] FAULT_NONE  = 3'd0;
	localparam logic [2:0] FAULT_ADC   = 3'd1;
	localparam logic [2:0] FAULT_SAT   = 3'd2;
	localparam logic [2:0] FAULT_UNDER = 3'd3;
	localparam logic [2:0] FAULT_OVER  = 3'd4;

	localparam logic [15:0] SHUNT_RESET    = 16'd16500;
	localparam logic [15:0] CUR_LOW_RESET  = 16'd4000;
	localparam logic [15:0] CUR_HIGH_RESET = 16'd20000;
	localparam logic [31:0] ENG_LOW_RESET  = 32'd0;
	localparam logic [31:0] ENG_HIGH_RESET = 32'd100000;
	localparam logic [16:0] ALPHA_ONE      = 17'd65536;

	localparam logic [15:0] SAT_VOLT     = 16'd32800;
	localparam logic [16:0] UNDER_UA     = 17'd3600;
	localparam logic [16:0] OVER_UA      = 17'd20800;
	localparam logic [16:0] CUR_MAX      = 17'h1FFFF;
	localparam logic [13:0] UA_SCALE     = 14'd10000;

	localparam int         PROD_W        = 30;
	localparam int         ALPHA_BITS    = 17;
	localparam int         ALPHA_SHIFT   = 16;
	localparam logic [4:0] DIV_CUR_STEPS = 5'd30;
	localparam logic [4:0] MUL_FILT_STEPS = 5'd17;

	typedef enum logic {
		ALU_DIV,
		ALU_MUL
	} alu_mode_t;

	typedef struct packed {
		logic       start;
		alu_mode_t  mode;
		logic [4:0] steps;
	} alu_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CUR_GO,
		ST_CUR_RUN,
		ST_WIN,
		ST_N_RUN,
		ST_SCL_GO,
		ST_SCL_RUN,
		ST_FILT_GO,
		ST_FILT_RUN,
		ST_OUT
	} seq_state_t;

endpackage

`default_nettype wire

FILE: rtl/clsc_alu.sv
// Shared shift-add / shift-subtract unit: one quotient or product bit per cycle.
`default_nettype none

module clsc_alu #(
	parameter int AW = 51,
	parameter int BW = 30
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire clsc_pkg::alu_cmd_t  cmd,
	input  wire logic [BW-1:0]       load_bits,
	input  wire logic [15:0]         load_rem,
	input  wire logic [15:0]         den,
	input  wire logic signed [32:0]  mcand,
	output logic                     done,
	output logic [AW-1:0]            acc,
	output logic [BW-1:0]            bits
);
	import clsc_pkg::*;

	logic            busy_q;
	logic            done_q;
	alu_mode_t       mode_q;
	logic [4:0]      cnt_q;
	logic [AW-1:0]   acc_q;
	logic [BW-1:0]   bits_q;

	logic [AW-1:0]   sh;
	logic [AW-1:0]   addend;
	logic [AW-1:0]   sum;
	logic            qbit;
	logic [AW-1:0]   acc_n;

	always_comb begin
		sh = {acc_q[AW-2:0], (mode_q == ALU_DIV) ? bits_q[BW-1] : 1'b0};
		if (mode_q == ALU_DIV) begin
			addend = {AW{1'b0}} - {{(AW-16){1'b0}}, den};
		end else if (bits_q[BW-1]) begin
			addend = {{(AW-33){mcand[32]}}, mcand};
		end else begin
			addend = {AW{1'b0}};
		end
		sum   = sh + addend;
		qbit  = (mode_q == ALU_DIV) && !sum[AW-1];
		acc_n = ((mode_q == ALU_DIV) && !qbit) ? sh : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= ALU_DIV;
			cnt_q  <= 5'd0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			mode_q <= cmd.mode;
			cnt_q  <= cmd.steps;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 5'd1;
			busy_q <= (cnt_q != 5'd1);
			done_q <= (cnt_q == 5'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q  <= (cmd.mode == ALU_DIV) ? {{(AW-16){1'b0}}, load_rem} : {AW{1'b0}};
			bits_q <= load_bits;
		end else if (busy_q) begin
			acc_q  <= acc_n;
			bits_q <= {bits_q[BW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign acc  = acc_q;
	assign bits = bits_q;

endmodule

`default_nettype wire

FILE: rtl/current_loop_sensor_conditioner.sv
// Top level of the current-loop sensor conditioner: sequencer, registers and datapath.
//
// Usage:
//   sample channel: one shunt-voltage word (0.1 mV units) plus converter flag,
//   valid/ready. result channel: loop current, fault code, scaled and filtered
//   engineering value, valid/ready. Config: write cfg_wdata to the register
//   at cfg_index when cfg_wr_en is high; write only while the block is idle.
// Operation:
//   One word is worked at a time through a shared one-bit-per-cycle
//   divide/multiply unit: a 30-step current division, a FRACTION_BITS-step
//   window division, a (FRACTION_BITS+1)-step scaling multiply and a 17-step
//   filter multiply. A zero shunt skips the current division, and a current
//   outside the window skips the window division. sample_ready is high only
//   between words, so a new word is taken only once the last one has left
//   the sequencer.
// Reset: registers take their default values, filter memory clears to zero.
// Stall: a finished result waits in the output register; the next sample is
//   taken meanwhile and its result holds in the sequencer until the output
//   register frees.
`default_nettype none

module current_loop_sensor_conditioner #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	output logic                    sample_ready,
	input  wire clsc_pkg::sample_t  sample,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output clsc_pkg::result_t       result,
	input  wire logic               cfg_wr_en,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_wdata
);
	import clsc_pkg::*;

	localparam int F  = FRACTION_BITS;
	localparam int BW = (F + 1 > PROD_W) ? F + 1 : PROD_W;
	localparam int AW = 35 + ((F > 16) ? F : 16);

	seq_state_t state_q, state_n;

	logic [15:0] shunt_q;
	logic [15:0] cur_low_q;
	logic [15:0] cur_high_q;
	logic [31:0] eng_low_q;
	logic [31:0] eng_high_q;
	logic [16:0] alpha_q;

	logic [PROD_W-1:0] prod_q;
	logic              ok_q;
	logic              sat_q;
	logic [16:0]       cur_q;
	logic [F:0]        n_q;
	logic [31:0]       scaled_q;
	logic [31:0]       mem_q;
	result_t           res_q;
	logic              res_valid_q;

	alu_cmd_t          alu_cmd;
	logic [BW-1:0]     alu_load_bits;
	logic [15:0]       alu_load_rem;
	logic [15:0]       alu_den;
	logic signed [32:0] alu_mcand;
	logic              alu_done;
	logic [AW-1:0]     alu_acc;
	logic [BW-1:0]     alu_bits;

	logic              win_empty;
	logic              below;
	logic              above;
	logic [15:0]       span;
	logic [15:0]       rem0;
	logic [32:0]       eng_diff;
	logic [32:0]       filt_diff;
	logic [16:0]       alpha_sat;
	logic [16:0]       cur_div;
	logic [2:0]        fault;
	logic [31:0]       scaled_next;
	logic [31:0]       filt_next;
	logic              out_free;

	clsc_alu #(
		.AW(AW),
		.BW(BW)
	) u_alu (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (alu_cmd),
		.load_bits(alu_load_bits),
		.load_rem (alu_load_rem),
		.den      (alu_den),
		.mcand    (alu_mcand),
		.done     (alu_done),
		.acc      (alu_acc),
		.bits     (alu_bits)
	);

	always_comb begin
		win_empty   = cur_high_q <= cur_low_q;
		below       = cur_q <= {1'b0, cur_low_q};
		above       = cur_q >= {1'b0, cur_high_q};
		span        = cur_high_q - cur_low_q;
		rem0        = cur_q[15:0] - cur_low_q;
		eng_diff    = {eng_high_q[31], eng_high_q} - {eng_low_q[31], eng_low_q};
		filt_diff   = {scaled_q[31], scaled_q} - {mem_q[31], mem_q};
		alpha_sat   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
		cur_div     = (|alu_bits[PROD_W-1:17]) ? CUR_MAX : alu_bits[16:0];
		scaled_next = eng_low_q + alu_acc[F+31:F];
		filt_next   = mem_q + alu_acc[ALPHA_SHIFT+31:ALPHA_SHIFT];
		out_free    = !res_valid_q || result_ready;
		if (!ok_q) begin
			fault = FAULT_ADC;
		end else if (sat_q) begin
			fault = FAULT_SAT;
		end else if (cur_q < UNDER_UA) begin
			fault = FAULT_UNDER;
		end else if (cur_q > OVER_UA) begin
			fault = FAULT_OVER;
		end else begin
			fault = FAULT_NONE;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) state_n = ST_CUR_GO;
			end
			ST_CUR_GO: begin
				state_n = (shunt_q == 16'd0) ? ST_WIN : ST_CUR_RUN;
			end
			ST_CUR_RUN: begin
				if (alu_done) state_n = ST_WIN;
			end
			ST_WIN: begin
				if (win_empty) state_n = ST_FILT_GO;
				else if (below || above) state_n = ST_SCL_GO;
				else state_n = ST_N_RUN;
			end
			ST_N_RUN: begin
				if (alu_done) state_n = ST_SCL_GO;
			end
			ST_SCL_GO: begin
				state_n = ST_SCL_RUN;
			end
			ST_SCL_RUN: begin
				if (alu_done) state_n = ST_FILT_GO;
			end
			ST_FILT_GO: begin
				state_n = ST_FILT_RUN;
			end
			ST_FILT_RUN: begin
				if (alu_done) state_n = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_ready  = 1'b0;
		alu_cmd       = '{start: 1'b0, mode: ALU_DIV, steps: 5'd0};
		alu_load_bits = {BW{1'b0}};
		alu_load_rem  = 16'd0;
		alu_den       = (state_q == ST_CUR_GO || state_q == ST_CUR_RUN) ? shunt_q : span;
		alu_mcand     = (state_q == ST_SCL_GO || state_q == ST_SCL_RUN) ?
		                $signed(eng_diff) : $signed(filt_diff);
		unique case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
			end
			ST_CUR_GO: begin
				alu_cmd       = '{start: (shunt_q != 16'd0), mode: ALU_DIV, steps: DIV_CUR_STEPS};
				alu_load_bits = BW'(prod_q) << (BW - PROD_W);
			end
			ST_WIN: begin
				alu_cmd      = '{start: !win_empty && !below && !above, mode: ALU_DIV,
				                 steps: 5'(F)};
				alu_load_rem = rem0;
			end
			ST_SCL_GO: begin
				alu_cmd       = '{start: 1'b1, mode: ALU_MUL, steps: 5'(F + 1)};
				alu_load_bits = BW'(n_q) << (BW - F - 1);
			end
			ST_FILT_GO: begin
				alu_cmd       = '{start: 1'b1, mode: ALU_MUL, steps: MUL_FILT_STEPS};
				alu_load_bits = BW'(alpha_sat) << (BW - ALPHA_BITS);
			end
			ST_CUR_RUN, ST_N_RUN, ST_SCL_RUN, ST_FILT_RUN, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shunt_q    <= SHUNT_RESET;
			cur_low_q  <= CUR_LOW_RESET;
			cur_high_q <= CUR_HIGH_RESET;
			eng_low_q  <= ENG_LOW_RESET;
			eng_high_q <= ENG_HIGH_RESET;
			alpha_q    <= ALPHA_ONE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SHUNT:    shunt_q    <= cfg_wdata[15:0];
				REG_CUR_LOW:  cur_low_q  <= cfg_wdata[15:0];
				REG_CUR_HIGH: cur_high_q <= cfg_wdata[15:0];
				REG_ENG_LOW:  eng_low_q  <= cfg_wdata;
				REG_ENG_HIGH: eng_high_q <= cfg_wdata;
				REG_ALPHA:    alpha_q    <= cfg_wdata[16:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_q       <= 32'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FILT_RUN && alu_done) mem_q <= filt_next;
			if (state_q == ST_OUT && out_free) res_valid_q <= 1'b1;
			else if (result_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample_valid) begin
			prod_q <= PROD_W'(sample.sample_voltage) * PROD_W'(UA_SCALE);
			ok_q   <= sample.adc_ok;
			sat_q  <= sample.sample_voltage >= SAT_VOLT;
		end
		if (state_q == ST_CUR_GO && shunt_q == 16'd0) cur_q <= 17'd0;
		if (state_q == ST_CUR_RUN && alu_done) cur_q <= cur_div;
		if (state_q == ST_WIN) begin
			if (win_empty) scaled_q <= eng_low_q;
			else if (below) n_q <= {(F+1){1'b0}};
			else if (above) n_q <= (F+1)'(1) << F;
		end
		if (state_q == ST_N_RUN && alu_done) n_q <= {1'b0, alu_bits[F-1:0]};
		if (state_q == ST_SCL_RUN && alu_done) scaled_q <= scaled_next;
		if (state_q == ST_OUT && out_free) begin
			res_q.loop_current   <= cur_q;
			res_q.fault_code     <= fault;
			res_q.scaled_value   <= scaled_q;
			res_q.filtered_value <= mem_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire

FILE: rtl/clsc_checker.sv
// Port-level checks for the current-loop sensor conditioner, bound to the top level.
`default_nettype none

module clsc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               sample_valid,
	input wire logic               sample_ready,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire clsc_pkg::result_t  result
);
	import clsc_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample_ready still high after a word was taken");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result word changed or dropped");

	a_fault_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.fault_code == FAULT_NONE || result.fault_code == FAULT_ADC ||
		                  result.fault_code == FAULT_SAT || result.fault_code == FAULT_UNDER ||
		                  result.fault_code == FAULT_OVER))
		else $error("fault code out of range");

	a_no_fault_in_band: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.fault_code == FAULT_NONE |->
		result.loop_current >= UNDER_UA && result.loop_current <= OVER_UA)
		else $error("no fault reported for a current outside the band");

endmodule

bind current_loop_sensor_conditioner clsc_checker u_clsc_checker (.*);

`default_nettype wire
